/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers used by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising aclk edge, masked while in reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Implication checked on the following edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/plom_pkg.sv */
// ----------------------------------------------------------------------------
// plom_pkg
// Types and constants of the price level order matcher.
// ----------------------------------------------------------------------------
package plom_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_BITS     = 16;
    localparam int DEF_QTY_BITS    = 32;
    localparam int PRICE_BITS      = 32;

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_CROSS  = 2'd2,
        OP_QUERY  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        FLAG_NONE = 2'd0,
        FLAG_FOK  = 2'd1,
        FLAG_AON  = 2'd2,
        FLAG_IOC  = 2'd3
    } flag_t;

    typedef enum logic [3:0] {
        EV_OPEN      = 4'd0,
        EV_CHANGE    = 4'd1,
        EV_CANCEL    = 4'd2,
        EV_FILL      = 4'd3,
        EV_TRADE     = 4'd4,
        EV_REMAIN    = 4'd5,
        EV_NO_ACTION = 4'd6,
        EV_AON_ABORT = 4'd7,
        EV_NOT_FOUND = 4'd8,
        EV_VOLUME    = 4'd9
    } event_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_Q_RD,
        ST_Q_CHK,
        ST_F_RD,
        ST_F_CHK,
        ST_F_DONE,
        ST_SH_RD,
        ST_SH_WR,
        ST_X_RD,
        ST_X_CHK,
        ST_EMIT
    } state_t;

endpackage

/* rtl/core/plom_ram.sv */
// ----------------------------------------------------------------------------
// plom_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module plom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/plom_ctrl.sv */
// ----------------------------------------------------------------------------
// plom_ctrl
// Sequencer: walks the order queue in RAM and emits event words.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plom_ctrl import plom_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int QTY_BITS    = DEF_QTY_BITS,
    localparam int IDX_W      = $clog2(QUEUE_DEPTH),
    localparam int E_W        = ID_BITS + 2 * QTY_BITS + 2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [PRICE_BITS-1:0] level_price,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  logic [ID_BITS-1:0]    s_order_id,
    input  logic [PRICE_BITS-1:0] s_order_price,
    input  logic [QTY_BITS-1:0]   s_order_volume,
    input  logic [QTY_BITS-1:0]   s_order_filled,
    input  logic                  s_is_stop,
    input  logic [1:0]            s_order_flag,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_event_res,
    output logic [ID_BITS-1:0]    m_event_order_id,
    output logic [QTY_BITS-1:0]   m_event_volume,
    output logic [QTY_BITS-1:0]   m_event_filled,
    output logic                  m_is_maker,
    output logic                  m_last,
    output logic                  ram_we,
    output logic [IDX_W-1:0]      ram_waddr,
    output logic [E_W-1:0]        ram_wdata,
    output logic                  ram_re,
    output logic [IDX_W-1:0]      ram_raddr,
    input  logic [E_W-1:0]        ram_rdata
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [QTY_BITS-1:0] QMAX = '1;

    typedef struct packed {
        event_t              res;
        logic [ID_BITS-1:0]  id;
        logic [QTY_BITS-1:0] vol;
        logic [QTY_BITS-1:0] fil;
        logic                maker;
        logic                last;
    } ev_t;

    function automatic ev_t mk_ev(event_t r, logic [ID_BITS-1:0] i, logic [QTY_BITS-1:0] v,
                                  logic [QTY_BITS-1:0] f, logic mk, logic l);
        ev_t e;
        e.res   = r;
        e.id    = i;
        e.vol   = v;
        e.fil   = f;
        e.maker = mk;
        e.last  = l;
        return e;
    endfunction

    state_t              state_reg, state_next, ret_reg, ret_next;
    op_t                 op_reg, op_next;
    logic [ID_BITS-1:0]  id_reg, id_next;
    logic [QTY_BITS-1:0] vol_reg, vol_next, fil_reg, fil_next;
    logic                stop_reg, stop_next;
    logic [1:0]          flag_reg, flag_next;
    logic [CNT_W-1:0]    idx_reg, idx_next, pos_reg, pos_next, count_reg, count_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic                found_reg, found_next;
    logic [QTY_BITS-1:0] sum_reg, sum_next;
    logic [E_W-1:0]      ent_reg, ent_next;
    ev_t                 pend_reg [3];
    ev_t                 pend_next [3];
    logic [1:0]          pn_reg, pn_next, pi_reg, pi_next;
    logic                ov_reg, ov_next;
    ev_t                 out_reg, out_next;

    logic [ID_BITS-1:0]  rd_id;
    logic [QTY_BITS-1:0] rd_vol, rd_fil, rd_rem, need, new_fil;
    logic [1:0]          rd_flag;
    logic [QTY_BITS:0]   sum_wide;
    logic [IDX_W-1:0]    head_inc;
    logic                out_free;

    function automatic logic [IDX_W-1:0] slot(logic [IDX_W-1:0] h, logic [CNT_W-1:0] i);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(h) + (CNT_W + 1)'(i);
        if (s >= (CNT_W + 1)'(QUEUE_DEPTH)) begin
            s = s - (CNT_W + 1)'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    assign rd_id   = ram_rdata[E_W-1 -: ID_BITS];
    assign rd_vol  = ram_rdata[2*QTY_BITS+1 -: QTY_BITS];
    assign rd_fil  = ram_rdata[QTY_BITS+1 -: QTY_BITS];
    assign rd_flag = ram_rdata[1:0];
    assign rd_rem  = (rd_vol > rd_fil) ? rd_vol - rd_fil : '0;
    assign need    = vol_reg - fil_reg;
    assign new_fil = rd_fil + need;
    assign sum_wide = {1'b0, sum_reg} + {1'b0, rd_rem};
    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign out_free = !ov_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            head_reg  <= '0;
            ov_reg    <= 1'b0;
            pn_reg    <= '0;
            pi_reg    <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            head_reg  <= head_next;
            ov_reg    <= ov_next;
            pn_reg    <= pn_next;
            pi_reg    <= pi_next;
        end
        ret_reg   <= ret_next;
        op_reg    <= op_next;
        id_reg    <= id_next;
        vol_reg   <= vol_next;
        fil_reg   <= fil_next;
        stop_reg  <= stop_next;
        flag_reg  <= flag_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        sum_reg   <= sum_next;
        ent_reg   <= ent_next;
        out_reg   <= out_next;
        pend_reg  <= pend_next;
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        op_next    = op_reg;
        id_next    = id_reg;
        vol_next   = vol_reg;
        fil_next   = fil_reg;
        stop_next  = stop_reg;
        flag_next  = flag_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        count_next = count_reg;
        head_next  = head_reg;
        found_next = found_reg;
        sum_next   = sum_reg;
        ent_next   = ent_reg;
        pend_next  = pend_reg;
        pn_next    = pn_reg;
        pi_next    = pi_reg;
        ov_next    = ov_reg && !m_ready;
        out_next   = out_reg;
        ram_we     = 1'b0;
        ram_waddr  = '0;
        ram_wdata  = '0;
        ram_re     = 1'b0;
        ram_raddr  = '0;
        s_ready    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    op_next    = op_t'(s_operation);
                    id_next    = s_order_id;
                    vol_next   = s_order_volume;
                    fil_next   = s_order_filled;
                    stop_next  = s_is_stop;
                    flag_next  = s_order_flag;
                    idx_next   = '0;
                    sum_next   = '0;
                    found_next = 1'b0;
                    pn_next    = 2'd1;
                    pi_next    = '0;
                    ret_next   = ST_IDLE;
                    unique case (op_t'(s_operation))
                        OP_QUERY: state_next = ST_Q_RD;
                        OP_REMOVE: begin
                            if (s_order_price != level_price) begin
                                pend_next[0] = mk_ev(EV_NOT_FOUND, s_order_id, s_order_volume,
                                                     s_order_filled, 1'b0, 1'b1);
                                state_next = ST_EMIT;
                            end else begin
                                state_next = ST_F_RD;
                            end
                        end
                        OP_CROSS: begin
                            if (s_is_stop) begin
                                state_next = ST_F_RD;
                            end else if (s_order_filled >= s_order_volume) begin
                                pend_next[0] = mk_ev(EV_NO_ACTION, s_order_id, s_order_volume,
                                                     s_order_filled, 1'b0, 1'b1);
                                state_next = ST_EMIT;
                            end else begin
                                state_next = ST_X_RD;
                            end
                        end
                        default: state_next = ST_F_RD;
                    endcase
                end
            end
            ST_Q_RD: begin
                if (idx_reg == count_reg) begin
                    pend_next[0] = mk_ev(EV_VOLUME, id_reg, sum_reg, '0, 1'b0, 1'b1);
                    pn_next    = 2'd1;
                    pi_next    = '0;
                    ret_next   = ST_IDLE;
                    state_next = ST_EMIT;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot(head_reg, idx_reg);
                    state_next = ST_Q_CHK;
                end
            end
            ST_Q_CHK: begin
                sum_next   = sum_wide[QTY_BITS] ? QMAX : sum_wide[QTY_BITS-1:0];
                idx_next   = idx_reg + 1'b1;
                state_next = ST_Q_RD;
            end
            ST_F_RD: begin
                if (idx_reg == count_reg) begin
                    state_next = ST_F_DONE;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot(head_reg, idx_reg);
                    state_next = ST_F_CHK;
                end
            end
            ST_F_CHK: begin
                if (rd_id == id_reg) begin
                    found_next = 1'b1;
                    pos_next   = idx_reg;
                    ent_next   = ram_rdata;
                    state_next = ST_F_DONE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_F_RD;
                end
            end
            ST_F_DONE: begin
                pn_next    = 2'd1;
                pi_next    = '0;
                ret_next   = ST_IDLE;
                state_next = ST_EMIT;
                if (op_reg == OP_REMOVE) begin
                    if (!found_reg) begin
                        pend_next[0] = mk_ev(EV_NOT_FOUND, id_reg, vol_reg, fil_reg, 1'b0, 1'b1);
                    end else begin
                        pend_next[0] = mk_ev(EV_CANCEL, ent_reg[E_W-1 -: ID_BITS],
                                             ent_reg[2*QTY_BITS+1 -: QTY_BITS],
                                             ent_reg[QTY_BITS+1 -: QTY_BITS], 1'b0, 1'b1);
                        idx_next = pos_reg;
                        ret_next = ST_SH_RD;
                    end
                end else if (stop_reg) begin
                    pend_next[0] = mk_ev(EV_NO_ACTION, id_reg, vol_reg, fil_reg, 1'b0, 1'b1);
                    if (!found_reg && count_reg < DEPTH_C) begin
                        ram_we     = 1'b1;
                        ram_waddr  = slot(head_reg, count_reg);
                        ram_wdata  = {id_reg, vol_reg, fil_reg, flag_reg};
                        count_next = count_reg + 1'b1;
                    end
                end else if (found_reg) begin
                    ram_we       = 1'b1;
                    ram_waddr    = slot(head_reg, pos_reg);
                    ram_wdata    = {id_reg, vol_reg, fil_reg, flag_reg};
                    pend_next[0] = mk_ev(EV_CHANGE, id_reg, vol_reg, fil_reg, 1'b0, 1'b1);
                end else if (count_reg >= DEPTH_C) begin
                    pend_next[0] = mk_ev(EV_NO_ACTION, id_reg, vol_reg, fil_reg, 1'b0, 1'b1);
                end else begin
                    ram_we       = 1'b1;
                    ram_waddr    = slot(head_reg, count_reg);
                    ram_wdata    = {id_reg, vol_reg, fil_reg, flag_reg};
                    count_next   = count_reg + 1'b1;
                    pend_next[0] = mk_ev(EV_OPEN, id_reg, vol_reg, fil_reg, 1'b0, 1'b1);
                end
            end
            ST_SH_RD: begin
                if (idx_reg + 1'b1 >= count_reg) begin
                    count_next = count_reg - 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = slot(head_reg, idx_reg + 1'b1);
                    state_next = ST_SH_WR;
                end
            end
            ST_SH_WR: begin
                ram_we     = 1'b1;
                ram_waddr  = slot(head_reg, idx_reg);
                ram_wdata  = ram_rdata;
                idx_next   = idx_reg + 1'b1;
                state_next = ST_SH_RD;
            end
            ST_X_RD: begin
                if (fil_reg >= vol_reg || count_reg == '0) begin
                    pend_next[0] = mk_ev((fil_reg >= vol_reg) ? EV_TRADE : EV_REMAIN,
                                         id_reg, vol_reg, fil_reg, 1'b0, 1'b1);
                    pn_next    = 2'd1;
                    pi_next    = '0;
                    ret_next   = ST_IDLE;
                    state_next = ST_EMIT;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = head_reg;
                    state_next = ST_X_CHK;
                end
            end
            ST_X_CHK: begin
                pi_next    = '0;
                ret_next   = ST_X_RD;
                state_next = ST_EMIT;
                head_next  = head_inc;
                count_next = count_reg - 1'b1;
                if (rd_rem > need) begin
                    if (rd_flag == FLAG_FOK || rd_flag == FLAG_AON) begin
                        pend_next[0] = mk_ev(EV_CANCEL, rd_id, rd_vol, rd_fil, 1'b1, 1'b0);
                        pn_next = 2'd1;
                    end else begin
                        fil_next     = vol_reg;
                        pend_next[0] = mk_ev(EV_FILL, id_reg, vol_reg, vol_reg, 1'b0, 1'b0);
                        pend_next[1] = mk_ev(EV_CHANGE, rd_id, rd_vol, new_fil, 1'b1, 1'b0);
                        if (rd_flag == FLAG_IOC) begin
                            pend_next[2] = mk_ev(EV_CANCEL, rd_id, rd_vol, new_fil, 1'b1, 1'b0);
                            pn_next = 2'd3;
                        end else begin
                            ram_we     = 1'b1;
                            ram_waddr  = head_reg;
                            ram_wdata  = {rd_id, rd_vol, new_fil, rd_flag};
                            head_next  = head_reg;
                            count_next = count_reg;
                            pn_next    = 2'd2;
                        end
                    end
                end else if (rd_rem < need) begin
                    fil_next = fil_reg + rd_rem;
                    if (flag_reg == FLAG_AON) begin
                        head_next    = head_reg;
                        count_next   = count_reg;
                        pend_next[0] = mk_ev(EV_AON_ABORT, id_reg, vol_reg, fil_reg + rd_rem,
                                             1'b0, 1'b1);
                        pn_next  = 2'd1;
                        ret_next = ST_IDLE;
                    end else begin
                        pend_next[0] = mk_ev(EV_CHANGE, id_reg, vol_reg, fil_reg + rd_rem,
                                             1'b0, 1'b0);
                        pend_next[1] = mk_ev(EV_FILL, rd_id, rd_vol, rd_vol, 1'b1, 1'b0);
                        pn_next = 2'd2;
                    end
                end else begin
                    fil_next     = vol_reg;
                    pend_next[0] = mk_ev(EV_FILL, id_reg, vol_reg, vol_reg, 1'b0, 1'b0);
                    pend_next[1] = mk_ev(EV_FILL, rd_id, rd_vol, rd_vol, 1'b1, 1'b0);
                    pn_next = 2'd2;
                end
            end
            ST_EMIT: begin
                if (pi_reg == pn_reg) begin
                    state_next = ret_reg;
                end else if (out_free) begin
                    ov_next  = 1'b1;
                    out_next = pend_reg[pi_reg];
                    pi_next  = pi_reg + 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_valid          = ov_reg;
    assign m_event_res      = out_reg.res;
    assign m_event_order_id = out_reg.id;
    assign m_event_volume   = out_reg.vol;
    assign m_event_filled   = out_reg.fil;
    assign m_is_maker       = out_reg.maker;
    assign m_last           = out_reg.last;

    `ASSERT_CLK(a_count_bound, count_reg <= DEPTH_C, "queue count beyond depth")
    `ASSERT_CLK(a_pend_index, pi_reg <= pn_reg, "event index past pending count")
    `ASSERT_NEXT(a_accept_leaves_idle, s_valid && s_ready, state_reg != ST_IDLE,
                 "accepted word did not start work")

endmodule

/* rtl/core/price_level_order_matcher_top.sv */
// ----------------------------------------------------------------------------
// price_level_order_matcher_top
// One price level of an order book: FIFO of resting orders in RAM.
// ----------------------------------------------------------------------------
// Add and matching-price remove scan the live orders for the id; query sums remainders.
// Remove shifts the tail down one slot per moved entry after its cancel event.
// Cross: each maker is read from the queue head and its events emitted before the next.
// Throughput: one word at a time; the RAM read port paces each queue step.
// Reset: queue empty, head 0, level_price 0; RAM contents are not cleared.
module price_level_order_matcher_top import plom_pkg::*; #(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_BITS     = DEF_ID_BITS,
    parameter int QTY_BITS    = DEF_QTY_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [PRICE_BITS-1:0] cfg_wr_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_operation,
    input  logic [ID_BITS-1:0]    s_order_id,
    input  logic [PRICE_BITS-1:0] s_order_price,
    input  logic [QTY_BITS-1:0]   s_order_volume,
    input  logic [QTY_BITS-1:0]   s_order_filled,
    input  logic                  s_is_stop,
    input  logic [1:0]            s_order_flag,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_event_res,
    output logic [ID_BITS-1:0]    m_event_order_id,
    output logic [QTY_BITS-1:0]   m_event_volume,
    output logic [QTY_BITS-1:0]   m_event_filled,
    output logic                  m_is_maker,
    output logic                  m_last
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int E_W   = ID_BITS + 2 * QTY_BITS + 2;

    logic [PRICE_BITS-1:0] price_reg;
    logic                  ram_we, ram_re;
    logic [IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [E_W-1:0]        ram_wdata, ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            price_reg <= '0;
        end else if (cfg_wr_en) begin
            price_reg <= cfg_wr_data;
        end
    end

    plom_ram #(
        .WIDTH (E_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    plom_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS),
        .QTY_BITS    (QTY_BITS)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .level_price      (price_reg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_operation      (s_operation),
        .s_order_id       (s_order_id),
        .s_order_price    (s_order_price),
        .s_order_volume   (s_order_volume),
        .s_order_filled   (s_order_filled),
        .s_is_stop        (s_is_stop),
        .s_order_flag     (s_order_flag),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_event_res      (m_event_res),
        .m_event_order_id (m_event_order_id),
        .m_event_volume   (m_event_volume),
        .m_event_filled   (m_event_filled),
        .m_is_maker       (m_is_maker),
        .m_last           (m_last),
        .ram_we           (ram_we),
        .ram_waddr        (ram_waddr),
        .ram_wdata        (ram_wdata),
        .ram_re           (ram_re),
        .ram_raddr        (ram_raddr),
        .ram_rdata        (ram_rdata)
    );

endmodule

/* dv/price_level_order_matcher_top_tb.sv */
// ----------------------------------------------------------------------------
// price_level_order_matcher_top_tb
// Drives add, remove, cross and query words into one price level, predicts
// every event from a local model of the resting order queue and compares the
// result channel word by word. Level price is changed between phases.
// ----------------------------------------------------------------------------
module price_level_order_matcher_top_tb;
    import plom_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH    = 16;
    localparam int WDOG_MAX = 20000;

    typedef struct packed {
        op_t         op;
        logic [15:0] id;
        logic [31:0] price;
        logic [31:0] vol;
        logic [31:0] fil;
        logic        stop;
        logic [1:0]  flag;
    } order_word_t;

    typedef struct packed {
        event_t      res;
        logic [15:0] id;
        logic [31:0] vol;
        logic [31:0] fil;
        logic        maker;
        logic        last;
    } event_word_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [31:0] cfg_wr_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [1:0]  s_operation = 0;
    logic [15:0] s_order_id = 0;
    logic [31:0] s_order_price = 0;
    logic [31:0] s_order_volume = 0;
    logic [31:0] s_order_filled = 0;
    logic        s_is_stop = 0;
    logic [1:0]  s_order_flag = 0;
    logic        m_valid;
    logic        m_ready = 0;
    logic [3:0]  m_event_res;
    logic [15:0] m_event_order_id;
    logic [31:0] m_event_volume;
    logic [31:0] m_event_filled;
    logic        m_is_maker;
    logic        m_last;

    price_level_order_matcher_top u_top (.*);

    // model state
    logic [31:0] mdl_price;
    logic [15:0] bk_id [DEPTH];
    logic [31:0] bk_vol [DEPTH];
    logic [31:0] bk_fil [DEPTH];
    logic [1:0]  bk_flag [DEPTH];
    int          bk_head, bk_cnt;

    order_word_t pending_orders[$];
    event_word_t expected_events[$];
    event_word_t evq[$];
    int  errors = 0;
    int  wdog = 0;
    bit  idle_on = 0;
    bit  hold_sender = 0;
    int  accepted = 0;
    int  sent_target = 0;

    function automatic void queue_order(order_word_t w);
        pending_orders.insert(pending_orders.size(), w);
    endfunction

    function automatic order_word_t take_order();
        order_word_t w;
        w = pending_orders[0];
        pending_orders.delete(0);
        return w;
    endfunction

    function automatic event_word_t take_expected();
        event_word_t e;
        e = expected_events[0];
        expected_events.delete(0);
        return e;
    endfunction

    function automatic int slot(int i);
        return (bk_head + i) % DEPTH;
    endfunction

    function automatic logic [31:0] rem_of(int s);
        return bk_vol[s] > bk_fil[s] ? bk_vol[s] - bk_fil[s] : 32'd0;
    endfunction

    function automatic int find_order(logic [15:0] id);
        for (int i = 0; i < bk_cnt; i++)
            if (bk_id[slot(i)] == id) return i;
        return -1;
    endfunction

    function automatic void post(event_t r, logic [15:0] id, logic [31:0] v,
                                 logic [31:0] f, logic mk);
        event_word_t e;
        e.res = r; e.id = id; e.vol = v; e.fil = f; e.maker = mk; e.last = 0;
        evq.insert(evq.size(), e);
    endfunction

    function automatic void post_slot(event_t r, int s, logic mk);
        post(r, bk_id[s], bk_vol[s], bk_fil[s], mk);
    endfunction

    function automatic void push_order(order_word_t w);
        int s;
        s = slot(bk_cnt);
        bk_id[s] = w.id; bk_vol[s] = w.vol; bk_fil[s] = w.fil; bk_flag[s] = w.flag;
        bk_cnt++;
    endfunction

    function automatic void book_add(order_word_t w);
        int pos, s;
        pos = find_order(w.id);
        if (w.stop) begin
            if (pos < 0 && bk_cnt < DEPTH) push_order(w);
            post(EV_NO_ACTION, w.id, w.vol, w.fil, 0);
        end else if (pos >= 0) begin
            s = slot(pos);
            bk_vol[s] = w.vol; bk_fil[s] = w.fil; bk_flag[s] = w.flag;
            post_slot(EV_CHANGE, s, 0);
        end else if (bk_cnt >= DEPTH) begin
            post(EV_NO_ACTION, w.id, w.vol, w.fil, 0);
        end else begin
            push_order(w);
            post(EV_OPEN, w.id, w.vol, w.fil, 0);
        end
    endfunction

    function automatic void book_cross(order_word_t w);
        logic [31:0] fil, need, mrem;
        int s;
        fil = w.fil;
        if (w.stop) begin
            book_add(w);
            return;
        end
        if (fil >= w.vol) begin
            post(EV_NO_ACTION, w.id, w.vol, fil, 0);
            return;
        end
        while (fil < w.vol && bk_cnt > 0) begin
            need = w.vol - fil;
            s = bk_head;
            mrem = rem_of(s);
            bk_head = (bk_head + 1) % DEPTH;
            bk_cnt--;
            if (mrem > need) begin
                if (bk_flag[s] == FLAG_FOK || bk_flag[s] == FLAG_AON) begin
                    post_slot(EV_CANCEL, s, 1);
                    continue;
                end
                bk_fil[s] = bk_fil[s] + need;
                fil = w.vol;
                post(EV_FILL, w.id, w.vol, fil, 0);
                post_slot(EV_CHANGE, s, 1);
                if (bk_flag[s] == FLAG_IOC) post_slot(EV_CANCEL, s, 1);
                else begin
                    bk_head = (bk_head + DEPTH - 1) % DEPTH;
                    bk_cnt++;
                end
            end else if (mrem < need) begin
                fil = fil + mrem;
                if (w.flag == FLAG_AON) begin
                    bk_head = (bk_head + DEPTH - 1) % DEPTH;
                    bk_cnt++;
                    post(EV_AON_ABORT, w.id, w.vol, fil, 0);
                    return;
                end
                bk_fil[s] = bk_vol[s];
                post(EV_CHANGE, w.id, w.vol, fil, 0);
                post_slot(EV_FILL, s, 1);
            end else begin
                bk_fil[s] = bk_vol[s];
                fil = fil + mrem;
                post(EV_FILL, w.id, w.vol, fil, 0);
                post_slot(EV_FILL, s, 1);
            end
        end
        post(fil >= w.vol ? EV_TRADE : EV_REMAIN, w.id, w.vol, fil, 0);
    endfunction

    function automatic void predict_events(order_word_t w);
        int pos;
        logic [32:0] sum;
        evq = {};
        case (w.op)
            OP_ADD: book_add(w);
            OP_REMOVE: begin
                pos = find_order(w.id);
                if (w.price != mdl_price || pos < 0) begin
                    post(EV_NOT_FOUND, w.id, w.vol, w.fil, 0);
                end else begin
                    post_slot(EV_CANCEL, slot(pos), 0);
                    for (int i = pos; i + 1 < bk_cnt; i++) begin
                        bk_id[slot(i)]   = bk_id[slot(i + 1)];
                        bk_vol[slot(i)]  = bk_vol[slot(i + 1)];
                        bk_fil[slot(i)]  = bk_fil[slot(i + 1)];
                        bk_flag[slot(i)] = bk_flag[slot(i + 1)];
                    end
                    bk_cnt--;
                end
            end
            OP_CROSS: book_cross(w);
            default: begin
                sum = 0;
                for (int i = 0; i < bk_cnt; i++) begin
                    sum = sum + rem_of(slot(i));
                    if (sum[32]) sum = 33'h0_FFFF_FFFF;
                end
                post(EV_VOLUME, w.id, sum[31:0], 0, 0);
            end
        endcase
        evq[evq.size() - 1].last = 1;
        foreach (evq[i]) expected_events.insert(expected_events.size(), evq[i]);
    endfunction

    function automatic logic [31:0] rand_qty();
        case ($urandom_range(0, 5))
            0: return 32'hFFFF_FFFF;
            1: return 0;
            2: return $urandom;
            default: return $urandom_range(1, 100);
        endcase
    endfunction

    function automatic order_word_t mk(op_t op, logic [15:0] id, logic [31:0] pr,
                                       logic [31:0] v, logic [31:0] f,
                                       logic st, logic [1:0] fl);
        order_word_t w;
        w.op = op; w.id = id; w.price = pr; w.vol = v; w.fil = f;
        w.stop = st; w.flag = fl;
        return w;
    endfunction

    function automatic order_word_t rand_order(logic [31:0] pr);
        order_word_t w;
        w.op    = op_t'($urandom_range(0, 3));
        w.id    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
        w.price = ($urandom_range(0, 4) == 0) ? $urandom : pr;
        w.vol   = rand_qty();
        w.fil   = ($urandom_range(0, 2) == 0) ? rand_qty() : 32'($urandom_range(0, 10));
        w.stop  = ($urandom_range(0, 9) == 0);
        w.flag  = 2'($urandom_range(0, 3));
        return w;
    endfunction

    initial begin
        forever #4 aclk = ~aclk;
    end

    // driver
    always @(posedge aclk) begin
        if (s_valid && s_ready) accepted <= accepted + 1;
        if (!aresetn) begin
            s_valid <= 0;
        end else if (!s_valid || s_ready) begin
            if (pending_orders.size() > 0 && !hold_sender &&
                !(idle_on && $urandom_range(0, 99) < 31)) begin
                s_valid        <= 1;
                s_operation    <= pending_orders[0].op;
                s_order_id     <= pending_orders[0].id;
                s_order_price  <= pending_orders[0].price;
                s_order_volume <= pending_orders[0].vol;
                s_order_filled <= pending_orders[0].fil;
                s_is_stop      <= pending_orders[0].stop;
                s_order_flag   <= pending_orders[0].flag;
                predict_events(take_order());
            end else begin
                s_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            m_ready <= !(idle_on && $urandom_range(0, 99) < 31);
            if ((s_valid && s_ready) || (m_valid && m_ready)) wdog <= 0;
            else wdog <= wdog + 1;
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $error("unexpected word res=%0d", m_event_res);
                    errors++;
                end else begin
                    event_word_t e;
                    e = take_expected();
                    if (m_event_res !== e.res) begin
                        $error("event_res exp %0d got %0d", e.res, m_event_res);
                        errors++;
                    end
                    if (m_event_order_id !== e.id) begin
                        $error("event_order_id exp %0h got %0h", e.id, m_event_order_id);
                        errors++;
                    end
                    if (m_event_volume !== e.vol) begin
                        $error("event_volume exp %0h got %0h", e.vol, m_event_volume);
                        errors++;
                    end
                    if (m_event_filled !== e.fil) begin
                        $error("event_filled exp %0h got %0h", e.fil, m_event_filled);
                        errors++;
                    end
                    if (m_is_maker !== e.maker) begin
                        $error("is_maker exp %0d got %0d", e.maker, m_is_maker);
                        errors++;
                    end
                    if (m_last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, m_last);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (wdog >= WDOG_MAX) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_orders.size() > 0 || s_valid || expected_events.size() > 0)
            @(posedge aclk);
        repeat (80) @(posedge aclk);
    endtask

    task automatic set_price(logic [31:0] p);
        @(posedge aclk);
        cfg_wr_en   <= 1;
        cfg_wr_data <= p;
        mdl_price = p;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    initial begin
        logic [31:0] prices [4];
        prices = '{32'd0, 32'hFFFF_FFFF, 32'd1000, 32'h8000_0001};
        mdl_price = 0;
        bk_head = 0;
        bk_cnt = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;
        set_price(32'd1000);

        // directed
        queue_order(mk(OP_QUERY, 16'hFFFF, 0, 0, 0, 0, FLAG_NONE));
        queue_order(mk(OP_REMOVE, 1, 1000, 5, 0, 0, FLAG_NONE));
        queue_order(mk(OP_ADD, 1, 0, 10, 0, 0, FLAG_NONE));
        queue_order(mk(OP_ADD, 2, 0, 20, 5, 0, FLAG_FOK));
        queue_order(mk(OP_ADD, 3, 0, 32'hFFFF_FFFF, 0, 0, FLAG_IOC));
        queue_order(mk(OP_ADD, 4, 0, 30, 0, 0, FLAG_AON));
        queue_order(mk(OP_ADD, 1, 0, 12, 2, 0, FLAG_NONE));
        queue_order(mk(OP_ADD, 5, 0, 7, 0, 1, FLAG_NONE));
        queue_order(mk(OP_QUERY, 0, 0, 0, 0, 0, FLAG_NONE));
        queue_order(mk(OP_REMOVE, 2, 999, 0, 0, 0, FLAG_NONE));
        queue_order(mk(OP_REMOVE, 4, 1000, 0, 0, 0, FLAG_NONE));
        queue_order(mk(OP_CROSS, 9, 0, 5, 5, 0, FLAG_NONE));
        queue_order(mk(OP_CROSS, 10, 0, 10, 0, 0, FLAG_NONE));
        queue_order(mk(OP_CROSS, 11, 0, 40, 0, 0, FLAG_AON));
        queue_order(mk(OP_CROSS, 12, 0, 3, 0, 0, FLAG_NONE));
        queue_order(mk(OP_CROSS, 13, 0, 8, 0, 1, FLAG_NONE));
        queue_order(mk(OP_CROSS, 14, 0, 32'hFFFF_FFFF, 0, 0, FLAG_IOC));
        for (int i = 0; i < 17; i++)
            queue_order(mk(OP_ADD, 16'(100 + i), 0, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 0, 2'(i)));
        queue_order(mk(OP_QUERY, 0, 0, 0, 0, 0, FLAG_NONE));
        queue_order(mk(OP_CROSS, 15, 0, 32'hFFFF_FFFF, 0, 0, FLAG_NONE));
        wait_drained();

        // random phases, one with no idling
        for (int ph = 0; ph < 4; ph++) begin
            set_price(prices[ph]);
            idle_on = (ph != 1);
            for (int i = 0; i < 19; i++) begin
                if ($urandom_range(0, 2) == 0)
                    queue_order(mk(OP_ADD, 16'($urandom_range(0, 20)), 0,
                        32'($urandom_range(1, 60)), 32'($urandom_range(0, 10)), 0,
                        2'($urandom_range(0, 3))));
                else
                    queue_order(rand_order(prices[ph]));
            end
            if (ph == 2) begin
                sent_target = accepted + 14;
                while (accepted < sent_target) @(posedge aclk);
                hold_sender = 1;
                while (s_valid || expected_events.size() > 0) @(posedge aclk);
                hold_sender = 0;
            end
            wait_drained();
        end

        if (errors == 0 && expected_events.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

/* price_level_order_matcher_top.f */
+incdir+rtl/core
rtl/core/plom_pkg.sv
rtl/core/plom_ram.sv
rtl/core/plom_ctrl.sv
rtl/core/price_level_order_matcher_top.sv
dv/price_level_order_matcher_top_tb.sv
